// ----- hdl/eisp_pkg.sv -----
// ----------------------------------------------------------------------------
// eisp_pkg
// types and constants shared by the eeprom image string parser
// ----------------------------------------------------------------------------
package eisp_pkg;

    localparam logic [7:0] SIG_BYTE0    = 8'h28;
    localparam logic [7:0] SIG_BYTE1    = 8'h32;
    localparam logic [7:0] SERIAL_MARK  = 8'ha5;
    localparam logic [7:0] STRING_TYPE  = 8'h03;
    localparam logic [6:0] CHAR_MAX     = 7'h7e;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_SHORT      = 3'd1,
        ST_SIGNATURE  = 3'd2,
        ST_RUNS_OFF   = 3'd3,
        ST_NOT_STRING = 3'd4,
        ST_ODD        = 3'd5,
        ST_NOT_TEXT   = 3'd6
    } status_t;

    typedef enum logic {
        KIND_CHAR   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_LOW  = 4'b0100,
        PH_HIGH = 4'b1000
    } phase_t;

    // results caused by one accepted byte
    typedef struct packed {
        logic        has_char;
        logic [6:0]  char_value;
        logic [1:0]  char_string;
        logic        has_status;
        status_t     status;
        logic [1:0]  status_string;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic        has_serial;
    } eisp_event_t;

    typedef struct packed {
        kind_t       kind;
        logic [1:0]  which_string;
        logic [6:0]  character;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic        has_serial;
        status_t     status;
        logic        last_of_run;
    } eisp_result_t;

endpackage

// ----- hdl/eisp_front.sv -----
// ----------------------------------------------------------------------------
// eisp_front
// parses image bytes, tracks descriptor walk and error precedence
// ----------------------------------------------------------------------------
module eisp_front #(
    parameter int STRINGS_START   = 9,
    parameter int MAX_IMAGE_BYTES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  logic [7:0]           byte_value,
    input  logic                 is_last,
    output logic                 ev_valid,
    output eisp_pkg::eisp_event_t ev
);
    import eisp_pkg::*;

    localparam int CNT_W   = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int MIN_LEN = STRINGS_START + 6;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      vid_reg, vid_next;
    logic [15:0]      pid_reg, pid_next;
    logic             serial_reg, serial_next;
    logic [1:0]       si_reg, si_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       left_reg, left_next;
    logic [7:0]       low_reg, low_next;
    status_t          held_reg, held_next;
    logic [1:0]       held_str_reg, held_str_next;
    logic             text_reg, text_next;
    logic             fin_reg, fin_next;

    logic             in_range;
    logic             walking;
    logic             done;
    logic [7:0]       left_sub;
    logic             bad_char;

    assign in_range = 32'(count_reg) < MAX_IMAGE_BYTES;
    assign left_sub = left_reg - 8'd2;
    assign bad_char = (byte_value != 8'd0) || (low_reg == 8'd0) || (low_reg > {1'b0, CHAR_MAX});

    always_comb begin
        count_next    = count_reg;
        vid_next      = vid_reg;
        pid_next      = pid_reg;
        serial_next   = serial_reg;
        si_next       = si_reg;
        phase_next    = phase_reg;
        left_next     = left_reg;
        low_next      = low_reg;
        held_next     = held_reg;
        held_str_next = held_str_reg;
        text_next     = text_reg;
        fin_next      = fin_reg;
        done          = 1'b0;
        walking       = 1'b0;
        ev            = '0;

        if (in_range) begin
            if (count_reg == CNT_W'(0) && byte_value != SIG_BYTE0 && held_reg == ST_OK) begin
                held_next     = ST_SIGNATURE;
                held_str_next = si_reg;
            end
            if (count_reg == CNT_W'(1) && byte_value != SIG_BYTE1 && held_reg == ST_OK) begin
                held_next     = ST_SIGNATURE;
                held_str_next = si_reg;
            end
            if (32'(count_reg) == 2) vid_next[7:0]  = byte_value;
            if (32'(count_reg) == 3) vid_next[15:8] = byte_value;
            if (32'(count_reg) == 4) pid_next[7:0]  = byte_value;
            if (32'(count_reg) == 5) pid_next[15:8] = byte_value;
            if (32'(count_reg) == 6) serial_next    = (byte_value == SERIAL_MARK);

            walking = (held_reg == ST_OK) && !fin_reg && (32'(count_reg) >= STRINGS_START);
            if (walking) begin
                case (phase_reg)
                    PH_LEN: begin
                        left_next  = byte_value;
                        text_next  = 1'b0;
                        phase_next = PH_TYPE;
                    end
                    PH_TYPE: begin
                        if (byte_value != STRING_TYPE) begin
                            held_next     = ST_NOT_STRING;
                            held_str_next = si_reg;
                        end else if (left_reg < 8'd2 || left_reg[0]) begin
                            held_next     = ST_ODD;
                            held_str_next = si_reg;
                        end else begin
                            left_next  = left_sub;
                            phase_next = PH_LOW;
                            done       = (left_sub == 8'd0);
                        end
                    end
                    PH_LOW: begin
                        low_next   = byte_value;
                        phase_next = PH_HIGH;
                    end
                    PH_HIGH: begin
                        if (!text_reg) begin
                            if (bad_char) begin
                                text_next = 1'b1;
                            end else begin
                                ev.has_char    = 1'b1;
                                ev.char_value  = low_reg[6:0];
                                ev.char_string = si_reg;
                            end
                        end
                        left_next  = (left_reg >= 8'd2) ? left_sub : 8'd0;
                        phase_next = PH_LOW;
                        done       = (left_next == 8'd0);
                    end
                    default: begin
                        phase_next = PH_LEN;
                    end
                endcase

                if (done) begin
                    if (text_next) begin
                        held_next     = ST_NOT_TEXT;
                        held_str_next = si_reg;
                    end else begin
                        phase_next = PH_LEN;
                        if (si_reg >= 2'd2) begin
                            fin_next = 1'b1;
                        end else begin
                            si_next = si_reg + 2'd1;
                        end
                    end
                end
            end
            count_next = count_reg + CNT_W'(1);
        end

        ev.vendor_id  = vid_next;
        ev.product_id = pid_next;
        ev.has_serial = serial_next;

        if (is_last) begin
            ev.has_status = 1'b1;
            if (32'(count_next) < MIN_LEN) begin
                ev.status = ST_SHORT;
            end else if (held_next != ST_OK) begin
                ev.status        = held_next;
                ev.status_string = (held_next == ST_SIGNATURE) ? 2'd0 : held_str_next;
            end else if (!fin_next) begin
                ev.status        = ST_RUNS_OFF;
                ev.status_string = si_next;
            end else begin
                ev.status = ST_OK;
            end

            count_next    = '0;
            vid_next      = '0;
            pid_next      = '0;
            serial_next   = 1'b0;
            si_next       = '0;
            phase_next    = PH_LEN;
            left_next     = '0;
            low_next      = '0;
            held_next     = ST_OK;
            held_str_next = '0;
            text_next     = 1'b0;
            fin_next      = 1'b0;
        end
    end

    assign ev_valid = in_accept && (ev.has_char || ev.has_status);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            vid_reg      <= '0;
            pid_reg      <= '0;
            serial_reg   <= 1'b0;
            si_reg       <= '0;
            phase_reg    <= PH_LEN;
            left_reg     <= '0;
            low_reg      <= '0;
            held_reg     <= ST_OK;
            held_str_reg <= '0;
            text_reg     <= 1'b0;
            fin_reg      <= 1'b0;
        end else if (in_accept) begin
            count_reg    <= count_next;
            vid_reg      <= vid_next;
            pid_reg      <= pid_next;
            serial_reg   <= serial_next;
            si_reg       <= si_next;
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            low_reg      <= low_next;
            held_reg     <= held_next;
            held_str_reg <= held_str_next;
            text_reg     <= text_next;
            fin_reg      <= fin_next;
        end
    end

endmodule

// ----- hdl/eisp_queue.sv -----
// ----------------------------------------------------------------------------
// eisp_queue
// short fifo of parse events between front and back
// ----------------------------------------------------------------------------
module eisp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  eisp_pkg::eisp_event_t push_data,
    input  logic                  pop,
    output eisp_pkg::eisp_event_t head,
    output logic                  empty,
    output logic                  full
);
    import eisp_pkg::*;

    eisp_event_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_reg, wr_next;
    logic [QPTR_W-1:0]   rd_reg, rd_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push;
    logic                do_pop;

    assign empty   = (cnt_reg == QCNT_W'(0));
    assign full    = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_next  = do_push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/eisp_back.sv -----
// ----------------------------------------------------------------------------
// eisp_back
// splits queued events into result transactions on a registered output
// ----------------------------------------------------------------------------
module eisp_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  eisp_pkg::eisp_event_t  head,
    input  logic                   empty,
    output logic                   pop,
    input  logic                   out_ready,
    output logic                   out_valid,
    output eisp_pkg::eisp_result_t out_data
);
    import eisp_pkg::*;

    logic         valid_reg, valid_next;
    logic         sent_reg, sent_next;
    eisp_result_t res_reg, res_next;
    logic         load;

    assign load = !empty && (!valid_reg || out_ready);

    always_comb begin
        res_next   = res_reg;
        sent_next  = sent_reg;
        pop        = 1'b0;
        valid_next = valid_reg && !out_ready;

        if (load) begin
            valid_next          = 1'b1;
            res_next.vendor_id  = head.vendor_id;
            res_next.product_id = head.product_id;
            res_next.has_serial = head.has_serial;
            if (head.has_char && !sent_reg) begin
                res_next.kind         = KIND_CHAR;
                res_next.which_string = head.char_string;
                res_next.character    = head.char_value;
                res_next.status       = ST_OK;
                res_next.last_of_run  = !head.has_status;
                sent_next             = head.has_status;
                pop                   = !head.has_status;
            end else begin
                res_next.kind         = KIND_STATUS;
                res_next.which_string = head.status_string;
                res_next.character    = '0;
                res_next.status       = head.status;
                res_next.last_of_run  = 1'b1;
                sent_next             = 1'b0;
                pop                   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

// ----- hdl/eeprom_image_string_parser.sv -----
// ----------------------------------------------------------------------------
// eeprom_image_string_parser
// eeprom header check and usb string descriptor walk, one byte per transaction
//
//   channel   direction   fields
//   s_        in          byte_value, is_last
//   m_        out         kind, which_string, character, vendor_id,
//                         product_id, has_serial, status, last_of_run
//
// one input byte per cycle while s_ready is high; the parser updates its state
// in the accept cycle; results leave one per cycle from a register while m_ready
// is high; a byte that ends a character and the image gives the character first
// a four-entry event queue sits between parser and output; s_ready drops
// only when it is full
// synchronous active-low reset clears parser state, queue and output valid
// ----------------------------------------------------------------------------
module eeprom_image_string_parser #(
    parameter int STRINGS_START   = 9,
    parameter int MAX_IMAGE_BYTES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_byte_value,
    input  logic                 s_is_last,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [1:0]           m_which_string,
    output logic [6:0]           m_character,
    output logic [15:0]          m_vendor_id,
    output logic [15:0]          m_product_id,
    output logic                 m_has_serial,
    output logic [2:0]           m_status,
    output logic                 m_last_of_run
);
    import eisp_pkg::*;

    logic         in_accept;
    logic         ev_valid;
    eisp_event_t  ev;
    eisp_event_t  head;
    logic         q_empty;
    logic         q_full;
    logic         pop;
    eisp_result_t res;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    eisp_front #(
        .STRINGS_START   (STRINGS_START),
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .byte_value (s_byte_value),
        .is_last    (s_is_last),
        .ev_valid   (ev_valid),
        .ev         (ev)
    );

    eisp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_valid),
        .push_data (ev),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    eisp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_data  (res)
    );

    assign m_kind         = res.kind;
    assign m_which_string = res.which_string;
    assign m_character    = res.character;
    assign m_vendor_id    = res.vendor_id;
    assign m_product_id   = res.product_id;
    assign m_has_serial   = res.has_serial;
    assign m_status       = res.status;
    assign m_last_of_run  = res.last_of_run;

    // a character transaction never carries an error code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_CHAR) |-> (m_status == ST_OK))
        else $error("character transaction with nonzero status");

    // the status always closes the run of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_STATUS) |-> m_last_of_run)
        else $error("status transaction not marked last");

    // emitted characters are nonzero and no greater than CHAR_MAX
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_CHAR) |-> (m_character != 7'd0 && m_character <= CHAR_MAX))
        else $error("character outside text range");

    // an event is never offered to a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid |-> !q_full)
        else $error("event lost at full queue");

endmodule

// ----- bench/eisp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eisp_checker
// watches both channels of the eeprom image string parser, predicts the
// character and status results of every accepted byte and compares each
// accepted result, field by field, with the oldest prediction
// ----------------------------------------------------------------------------
module eisp_checker #(
    parameter int STRINGS_START   = 9,
    parameter int MAX_IMAGE_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_is_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_kind,
    input  logic [1:0]  m_which_string,
    input  logic [6:0]  m_character,
    input  logic [15:0] m_vendor_id,
    input  logic [15:0] m_product_id,
    input  logic        m_has_serial,
    input  logic [2:0]  m_status,
    input  logic        m_last_of_run,
    output int          fail_count,
    output int          pending,
    output int          accepted_count,
    output int          char_count,
    output int          status_count
);
    import eisp_pkg::*;

    localparam int MIN_IMAGE_BYTES = STRINGS_START + 6;

    logic [8:0]   image_pos;
    logic [39:0]  header_bytes;
    logic [1:0]   string_sel;
    phase_t       phase;
    logic [7:0]   desc_left;
    logic [7:0]   low_byte;
    status_t      first_error;
    logic [1:0]   first_error_string;
    logic         text_bad;
    logic         walk_done;
    logic         field_bad;

    eisp_result_t predicted_results[$];

    task automatic clear_parser();
        image_pos          = '0;
        header_bytes       = '0;
        string_sel         = '0;
        phase              = PH_LEN;
        desc_left          = '0;
        low_byte           = '0;
        first_error        = ST_OK;
        first_error_string = '0;
        text_bad           = 1'b0;
        walk_done          = 1'b0;
    endtask

    function automatic eisp_result_t make_result(input kind_t k, input logic [1:0] which,
                                                 input logic [6:0] ch, input status_t st);
        eisp_result_t r;
        r.kind         = k;
        r.which_string = which;
        r.character    = ch;
        r.vendor_id    = header_bytes[15:0];
        r.product_id   = header_bytes[31:16];
        r.has_serial   = (header_bytes[39:32] == SERIAL_MARK);
        r.status       = st;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic hold_error(input status_t code);
        first_error        = code;
        first_error_string = string_sel;
    endtask

    task automatic close_descriptor();
        if (text_bad) begin
            hold_error(ST_NOT_TEXT);
        end else begin
            phase = PH_LEN;
            if (string_sel >= 2'd2) begin
                walk_done = 1'b1;
            end else begin
                string_sel = string_sel + 2'd1;
            end
        end
    endtask

    task automatic parse_image_byte(input logic [7:0] b, input logic last);
        eisp_result_t made [2];
        int           n;
        int           at;
        logic [15:0]  ch;
        status_t      st;
        logic [1:0]   which;
        n = 0;
        if (image_pos < MAX_IMAGE_BYTES) begin
            at = image_pos;
            if (at == 0 && b != SIG_BYTE0 && first_error == ST_OK) hold_error(ST_SIGNATURE);
            if (at == 1 && b != SIG_BYTE1 && first_error == ST_OK) hold_error(ST_SIGNATURE);
            if (at >= 2 && at <= 6) header_bytes[8*(at-2) +: 8] = b;
            if (first_error == ST_OK && !walk_done && at >= STRINGS_START) begin
                case (phase)
                    PH_LEN: begin
                        desc_left = b;
                        text_bad  = 1'b0;
                        phase     = PH_TYPE;
                    end
                    PH_TYPE: begin
                        if (b != STRING_TYPE) begin
                            hold_error(ST_NOT_STRING);
                        end else if (desc_left < 8'd2 || desc_left[0]) begin
                            hold_error(ST_ODD);
                        end else begin
                            desc_left = desc_left - 8'd2;
                            phase     = PH_LOW;
                            if (desc_left == 8'd0) close_descriptor();
                        end
                    end
                    PH_LOW: begin
                        low_byte = b;
                        phase    = PH_HIGH;
                    end
                    default: begin
                        ch = {b, low_byte};
                        if (!text_bad) begin
                            if (ch == 16'd0 || ch > 16'(CHAR_MAX)) begin
                                text_bad = 1'b1;
                            end else begin
                                made[n] = make_result(KIND_CHAR, string_sel, ch[6:0], ST_OK);
                                n++;
                            end
                        end
                        desc_left = (desc_left >= 8'd2) ? desc_left - 8'd2 : 8'd0;
                        phase     = PH_LOW;
                        if (desc_left == 8'd0) close_descriptor();
                    end
                endcase
            end
            image_pos = 9'(at + 1);
        end
        if (last) begin
            which = 2'd0;
            if (image_pos < MIN_IMAGE_BYTES) begin
                st = ST_SHORT;
            end else if (first_error != ST_OK) begin
                st    = first_error;
                which = (first_error == ST_SIGNATURE) ? 2'd0 : first_error_string;
            end else if (!walk_done) begin
                st    = ST_RUNS_OFF;
                which = string_sel;
            end else begin
                st = ST_OK;
            end
            made[n] = make_result(KIND_STATUS, which, 7'd0, st);
            n++;
        end
        if (n > 0) made[n-1].last_of_run = 1'b1;
        for (int i = 0; i < n; i++) predicted_results.insert(predicted_results.size(), made[i]);
        if (last) clear_parser();
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            field_bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        eisp_result_t want;
        if (!aresetn) begin
            clear_parser();
            predicted_results.delete();
            fail_count     = 0;
            accepted_count = 0;
            char_count     = 0;
            status_count   = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d string %0d char %0d status %0d",
                             $time, m_kind, m_which_string, m_character, m_status);
                    fail_count++;
                end else begin
                    want      = predicted_results.pop_front();
                    field_bad = 1'b0;
                    check_field("kind", want.kind, m_kind);
                    check_field("which_string", want.which_string, m_which_string);
                    check_field("character", want.character, m_character);
                    check_field("vendor_id", want.vendor_id, m_vendor_id);
                    check_field("product_id", want.product_id, m_product_id);
                    check_field("has_serial", want.has_serial, m_has_serial);
                    check_field("status", want.status, m_status);
                    check_field("last_of_run", want.last_of_run, m_last_of_run);
                    if (field_bad) fail_count++;
                    if (want.kind == KIND_STATUS) begin
                        status_count++;
                    end else begin
                        char_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                parse_image_byte(s_byte_value, s_is_last);
                accepted_count++;
            end
        end
        pending = predicted_results.size();
    end

endmodule

// ----- bench/tb_eeprom_image_string_parser.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eeprom_image_string_parser
// drives eeprom images byte by byte into the parser: a few directed images,
// then random well-formed images with injected defects, noise
// and oversized images, with random idling on both channels and one long
// receiver hold-off; a separate checker predicts and compares the results
// ----------------------------------------------------------------------------
module tb_eeprom_image_string_parser;
    import eisp_pkg::*;

    localparam int STRINGS_START   = 9;
    localparam int MAX_IMAGE_BYTES = 256;
    localparam int MIN_IMAGE_BYTES = STRINGS_START + 6;
    localparam int RANDOM_BYTES    = 1300;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 16;
    localparam int LIMIT_CYCLES    = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_byte_value;
    logic        s_is_last;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [1:0]  m_which_string;
    logic [6:0]  m_character;
    logic [15:0] m_vendor_id;
    logic [15:0] m_product_id;
    logic        m_has_serial;
    logic [2:0]  m_status;
    logic        m_last_of_run;

    int fail_count;
    int pending;
    int accepted_count;
    int char_count;
    int status_count;

    int cycle_count  = 0;
    int bytes_sent   = 0;
    int images_sent  = 0;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;

    logic [7:0] img[$];

    eeprom_image_string_parser #(
        .STRINGS_START   (STRINGS_START),
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_which_string (m_which_string),
        .m_character    (m_character),
        .m_vendor_id    (m_vendor_id),
        .m_product_id   (m_product_id),
        .m_has_serial   (m_has_serial),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run)
    );

    eisp_checker #(
        .STRINGS_START   (STRINGS_START),
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES)
    ) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_byte_value   (s_byte_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_which_string (m_which_string),
        .m_character    (m_character),
        .m_vendor_id    (m_vendor_id),
        .m_product_id   (m_product_id),
        .m_has_serial   (m_has_serial),
        .m_status       (m_status),
        .m_last_of_run  (m_last_of_run),
        .fail_count     (fail_count),
        .pending        (pending),
        .accepted_count (accepted_count),
        .char_count     (char_count),
        .status_count   (status_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_eeprom_image_string_parser: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] id_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 8'h00;
        if (r < 4) return 8'hff;
        return 8'($urandom);
    endfunction

    // append one byte to the image under construction
    task automatic add_byte(input logic [7:0] v);
        img.insert(img.size(), v);
    endtask

    // receiver: random ready with one long hold-off once enough bytes went in
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        m_ready   = 1'b0;
        while (!aresetn) @(negedge aclk);
        forever begin
            if (hold_request && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap() + 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int target;
        int gap;
        target = accepted_count + 1;
        s_valid      <= 1'b1;
        s_byte_value <= value;
        s_is_last    <= last;
        @(negedge aclk);
        while (accepted_count != target) @(negedge aclk);
        bytes_sent++;
        if (bytes_sent >= HOLD_AFTER) hold_request = 1'b1;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_image();
        for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
        images_sent++;
    endtask

    // well-formed image with a random defect and maybe a flipped signature bit, or noise, or an oversized image
    task automatic build_image(input bit oversize);
        int         desc_at [3];
        int         nchars [3];
        int         defect;
        int         s;
        int         pos;
        int         cut;
        int         len;
        logic [7:0] v;
        defect = oversize ? 99 : $urandom_range(0, 99);
        s      = $urandom_range(0, 2);
        img.delete();
        add_byte(SIG_BYTE0);
        add_byte(SIG_BYTE1);
        repeat (4) add_byte(id_byte());
        add_byte($urandom_range(0, 1) ? SERIAL_MARK : 8'($urandom));
        while (img.size() < STRINGS_START) add_byte(8'($urandom));
        for (int d = 0; d < 3; d++) begin
            nchars[d] = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                    : $urandom_range(0, 4);
            if (defect >= 63 && defect < 75 && d == s && nchars[d] == 0) nchars[d] = 1;
            desc_at[d] = img.size();
            add_byte(8'(2 + 2 * nchars[d]));
            add_byte(STRING_TYPE);
            repeat (nchars[d]) begin
                add_byte(8'($urandom_range(1, CHAR_MAX)));
                add_byte(8'h00);
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            pos = $urandom_range(0, 1);
            img[pos] = img[pos] ^ 8'(1 << $urandom_range(0, 7));
        end
        if (defect < 45) begin
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
        end else if (defect < 55) begin
            v = 8'($urandom);
            if (v == STRING_TYPE) v = ~v;
            img[desc_at[s] + 1] = v;
        end else if (defect < 63) begin
            img[desc_at[s]] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1))
                                                          : (8'($urandom) | 8'h01);
        end else if (defect < 75) begin
            pos = desc_at[s] + 2 + 2 * $urandom_range(0, nchars[s] - 1);
            case ($urandom_range(0, 2))
                0: begin
                    img[pos]     = 8'h00;
                    img[pos + 1] = 8'h00;
                end
                1: img[pos + 1] = 8'($urandom_range(1, 255));
                default: img[pos] = 8'($urandom_range(8'h7f, 8'hff));
            endcase
        end else if (defect < 92) begin
            cut = ($urandom_range(0, 3) == 0) ? MIN_IMAGE_BYTES - 1 + $urandom_range(0, 1)
                                              : $urandom_range(1, img.size() - 1);
            while (img.size() > cut) img.pop_back();
        end else if (defect < 98) begin
            len = $urandom_range(1, 40);
            img.delete();
            if ($urandom_range(0, 1)) begin
                add_byte(SIG_BYTE0);
                add_byte(SIG_BYTE1);
            end
            while (img.size() < len) add_byte(8'($urandom));
        end else begin
            len = MAX_IMAGE_BYTES + $urandom_range(0, 20);
            while (img.size() < len) add_byte(8'($urandom));
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_byte_value = 8'h00;
        s_is_last    = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // one-byte image, minimal valid image with empty strings, two-byte image
        calm = 1'b1;
        img = '{8'hff};
        send_image();
        img = '{SIG_BYTE0, SIG_BYTE1, 8'hff, 8'hff, 8'hff, 8'hff, SERIAL_MARK, 8'h00, 8'h00,
                8'h02, STRING_TYPE, 8'h02, STRING_TYPE, 8'h02, STRING_TYPE};
        send_image();
        calm = 1'b0;
        img = '{SIG_BYTE0, SIG_BYTE1};
        send_image();

        while (bytes_sent < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 5) == 0);
            build_image(images_sent == 6 || images_sent == 30);
            send_image();
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d images, %0d bytes, %0d characters and %0d status results",
                 images_sent, bytes_sent, char_count, status_count);
        $display("receiver held off %0d cycles once, %0d cycles in total", HOLD_CYCLES,
                 cycle_count);
        if (fail_count == 0) begin
            $display("tb_eeprom_image_string_parser: done, clean");
        end else begin
            $display("tb_eeprom_image_string_parser: done, errors");
        end
        $finish;
    end

endmodule
